>>> sv/atdc_pkg.sv
`timescale 1ns / 1ps
package atdc_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SAMPLE_W            = 16;
    localparam int CFG_W               = 7;
    localparam int CFG_IDX_W           = 1;
    localparam int CODE_W              = 3;
    localparam int ANGLE_W             = 16;
    localparam int ACC_FRAC            = 20;
    localparam int CORDIC_STEPS        = 24;
    // cordic datapath: values stay below 2^31, with growth headroom
    localparam int CW                  = 34;
    localparam int SQ_W                = 32;
    localparam int ZW                  = 28;

    localparam logic [CFG_IDX_W-1:0] REG_TILT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 1'b1;

    localparam logic [CFG_W-1:0] TILT_RESET  = 7'd20;
    localparam logic [CFG_W-1:0] LEVEL_RESET = 7'd10;

    typedef enum logic [CODE_W-1:0] {
        TILT_NONE       = 3'd0,
        TILT_PITCH_UP   = 3'd1,
        TILT_PITCH_DOWN = 3'd2,
        TILT_ROLL_RIGHT = 3'd3,
        TILT_ROLL_LEFT  = 3'd4,
        TILT_LEVEL      = 3'd5
    } tilt_code_t;

    function automatic logic [ZW-1:0] atan_deg(input int i);
        logic [ZW-1:0] r;
        case (i)
            0:  r = 28'd47185920;
            1:  r = 28'd27855475;
            2:  r = 28'd14718068;
            3:  r = 28'd7471121;
            4:  r = 28'd3750058;
            5:  r = 28'd1876857;
            6:  r = 28'd938657;
            7:  r = 28'd469357;
            8:  r = 28'd234682;
            9:  r = 28'd117341;
            10: r = 28'd58670;
            11: r = 28'd29335;
            12: r = 28'd14667;
            13: r = 28'd7333;
            14: r = 28'd3666;
            15: r = 28'd1833;
            16: r = 28'd916;
            17: r = 28'd458;
            18: r = 28'd229;
            19: r = 28'd114;
            20: r = 28'd57;
            21: r = 28'd28;
            22: r = 28'd14;
            23: r = 28'd7;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/accel_tilt_direction_classifier_unit.sv
`timescale 1ns / 1ps
// Tilt classifier: each accepted sample yields exactly one result, strobed by
// done for one cycle. A new sample may be started every cycle; busy is never
// raised. done rises once the sample has passed the squares stage, 31 root
// bits at one per stage plus a load stage, cordic load and 24 cordic stages,
// scaling and classify; the result must be taken on the strobe cycle since it
// cannot be held off.
// Configuration writes apply to samples started after the write.
module accel_tilt_direction_classifier_unit #(
    parameter int ANGLE_FRAC_BITS = atdc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS     = atdc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic                                      cfg_we,
    input  logic [atdc_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [atdc_pkg::CFG_W-1:0]                cfg_data,
    input  logic signed [atdc_pkg::SAMPLE_W-1:0]      accel_x,
    input  logic signed [atdc_pkg::SAMPLE_W-1:0]      accel_y,
    input  logic signed [atdc_pkg::SAMPLE_W-1:0]      accel_z,
    input  logic [atdc_pkg::CODE_W-1:0]               button_event,
    output logic                                      done,
    output logic [atdc_pkg::CODE_W-1:0]               tilt_code,
    output logic [atdc_pkg::CODE_W-1:0]               button_code,
    output logic signed [atdc_pkg::ANGLE_W-1:0]       roll_angle,
    output logic signed [atdc_pkg::ANGLE_W-1:0]       pitch_angle
);
    import atdc_pkg::*;

    localparam int AW  = ANGLE_FRAC_BITS + 8;
    localparam int NW  = 2 * SAMPLE_BITS + 1;
    localparam int SW  = NW + 2 * (30 - SAMPLE_BITS);
    localparam int LAT = 1 + ((SW + 1) / 2 + 1) + 1 + CORDIC_STEPS + 1;

    logic [CFG_W-1:0] tilt_reg;
    logic [CFG_W-1:0] level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_reg  <= TILT_RESET;
            level_reg <= LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TILT:  tilt_reg  <= cfg_data;
                REG_LEVEL: level_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
    assign sx = accel_x[SAMPLE_BITS-1:0];
    assign sy = accel_y[SAMPLE_BITS-1:0];
    assign sz = accel_z[SAMPLE_BITS-1:0];

    logic                 roll_v, pitch_v;
    logic signed [AW-1:0] roll, pitch;

    atdc_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_roll (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .num(sy), .b(sx), .c(sz),
        .out_valid(roll_v), .angle(roll)
    );

    atdc_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_pitch (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .num(sx), .b(sy), .c(sz),
        .out_valid(pitch_v), .angle(pitch)
    );

    // button and thresholds travel alongside the angle pipes
    logic [CODE_W-1:0] btn_reg [LAT];
    logic [CFG_W-1:0]  thr_reg [LAT];
    logic [CFG_W-1:0]  lvl_reg [LAT];

    always_ff @(posedge clk)
    begin
        btn_reg[0] <= button_event;
        thr_reg[0] <= tilt_reg;
        lvl_reg[0] <= level_reg;
        for (int k = 1; k < LAT; k++)
        begin
            btn_reg[k] <= btn_reg[k-1];
            thr_reg[k] <= thr_reg[k-1];
            lvl_reg[k] <= lvl_reg[k-1];
        end
    end

    logic signed [AW+1:0] t, l, r, p;
    logic                 roll_lvl, pitch_lvl;
    tilt_code_t           code_next;

    always_comb
    begin
        t = $signed({2'b00, AW'(thr_reg[LAT-1]) << ANGLE_FRAC_BITS});
        l = $signed({2'b00, AW'(lvl_reg[LAT-1]) << ANGLE_FRAC_BITS});
        r = (AW+2)'(roll);
        p = (AW+2)'(pitch);
        roll_lvl  = (r >= -l) && (r <= l);
        pitch_lvl = (p >= -l) && (p <= l);
        if (p > t && roll_lvl)
            code_next = TILT_PITCH_UP;
        else if (p < -t && roll_lvl)
            code_next = TILT_PITCH_DOWN;
        else if (r > t && pitch_lvl)
            code_next = TILT_ROLL_RIGHT;
        else if (r < -t && pitch_lvl)
            code_next = TILT_ROLL_LEFT;
        else if (r > -t && r < t && pitch_lvl)
            code_next = TILT_LEVEL;
        else
            code_next = TILT_NONE;
    end

    logic                      done_reg;
    logic [CODE_W-1:0]         tilt_code_reg;
    logic [CODE_W-1:0]         button_code_reg;
    logic signed [ANGLE_W-1:0] roll_angle_reg;
    logic signed [ANGLE_W-1:0] pitch_angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= roll_v & pitch_v;
    end

    always_ff @(posedge clk)
    begin
        tilt_code_reg   <= code_next;
        button_code_reg <= btn_reg[LAT-1];
        roll_angle_reg  <= ANGLE_W'(r);
        pitch_angle_reg <= ANGLE_W'(p);
    end

    assign busy        = 1'b0;
    assign done        = done_reg;
    assign tilt_code   = tilt_code_reg;
    assign button_code = button_code_reg;
    assign roll_angle  = roll_angle_reg;
    assign pitch_angle = pitch_angle_reg;

`ifndef SYNTH
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        roll_v == pitch_v) else $error("angle lanes out of step");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        roll_v |=> done) else $error("result strobe lost");
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tilt_code_reg <= TILT_LEVEL)) else $error("bad tilt code");
    a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        done && tilt_code_reg == TILT_LEVEL |-> !$past(r > t))
        else $error("level with roll over threshold");
`endif

endmodule

>>> sv/atdc_angle.sv
`timescale 1ns / 1ps
// one pipelined angle: squares, bit-per-stage isqrt, one cordic step per stage
module atdc_angle #(
    parameter int ANGLE_FRAC_BITS = atdc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS     = atdc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [SAMPLE_BITS-1:0]       num,
    input  logic signed [SAMPLE_BITS-1:0]       b,
    input  logic signed [SAMPLE_BITS-1:0]       c,
    output logic                                out_valid,
    output logic signed [ANGLE_FRAC_BITS+7:0]   angle
);
    import atdc_pkg::*;

    localparam int PRE   = 30 - SAMPLE_BITS;
    localparam int NW    = 2 * SAMPLE_BITS + 1;      // b^2+c^2 width
    localparam int SW    = NW + 2 * PRE;              // radicand width
    localparam int RW    = (SW + 1) / 2;              // root bits
    localparam int SHV   = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int AW    = ANGLE_FRAC_BITS + 8;
    localparam int LS    = RW + 1;                    // sqrt stages
    localparam int NS    = CORDIC_STEPS;
    localparam logic [AW-1:0] LIM = AW'(90) << ANGLE_FRAC_BITS;

    // stage 0: squares and magnitude
    logic                   s0_v_reg;
    logic [NW-1:0]          s0_n_reg;
    logic [SAMPLE_BITS:0]   s0_mag_reg;
    logic                   s0_neg_reg;

    logic signed [2*SAMPLE_BITS-1:0] b_sq;
    logic signed [2*SAMPLE_BITS-1:0] c_sq;

    assign b_sq = b * b;
    assign c_sq = c * c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else
            s0_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s0_n_reg   <= NW'($unsigned(b_sq)) + NW'($unsigned(c_sq));
        s0_mag_reg <= num[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(-$signed({num[SAMPLE_BITS-1], num}))
                                         : (SAMPLE_BITS+1)'($signed({num[SAMPLE_BITS-1], num}));
        s0_neg_reg <= num[SAMPLE_BITS-1];
    end

    // restoring root of n << 2PRE, one result bit per stage
    logic                   q_v_reg   [LS];
    logic [SW+1:0]          q_rem_reg [LS];
    logic [RW-1:0]          q_root_reg[LS];
    logic [SAMPLE_BITS:0]   q_mag_reg [LS];
    logic                   q_neg_reg [LS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LS; k++)
                q_v_reg[k] <= 1'b0;
        end
        else
        begin
            q_v_reg[0] <= s0_v_reg;
            for (int k = 1; k < LS; k++)
                q_v_reg[k] <= q_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        q_rem_reg[0]  <= (SW+2)'({s0_n_reg, {(2 * PRE){1'b0}}});
        q_root_reg[0] <= '0;
        q_mag_reg[0]  <= s0_mag_reg;
        q_neg_reg[0]  <= s0_neg_reg;
    end

    for (genvar k = 1; k < LS; k++)
    begin : g_sqrt
        localparam int BP = RW - k;
        logic [SW+1:0] trial;
        logic [SW+1:0] rem_part;
        always_comb
        begin
            rem_part = q_rem_reg[k-1] >> (2 * BP);
            trial    = (SW+2)'({q_root_reg[k-1], 2'b01});
        end
        always_ff @(posedge clk)
        begin
            q_mag_reg[k] <= q_mag_reg[k-1];
            q_neg_reg[k] <= q_neg_reg[k-1];
            if (rem_part >= trial)
            begin
                q_rem_reg[k]  <= q_rem_reg[k-1] - (trial << (2 * BP));
                q_root_reg[k] <= {q_root_reg[k-1][RW-2:0], 1'b1};
            end
            else
            begin
                q_rem_reg[k]  <= q_rem_reg[k-1];
                q_root_reg[k] <= {q_root_reg[k-1][RW-2:0], 1'b0};
            end
        end
    end

    // cordic stages
    logic                  c_v_reg  [NS+1];
    logic signed [CW-1:0]  c_x_reg  [NS+1];
    logic signed [CW-1:0]  c_y_reg  [NS+1];
    logic signed [ZW:0]    c_z_reg  [NS+1];
    logic                  c_neg_reg[NS+1];
    logic                  c_zero_reg[NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                c_v_reg[k] <= 1'b0;
        end
        else
        begin
            c_v_reg[0] <= q_v_reg[LS-1];
            for (int k = 1; k <= NS; k++)
                c_v_reg[k] <= c_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        c_x_reg[0]    <= CW'(q_root_reg[LS-1]);
        c_y_reg[0]    <= CW'(q_mag_reg[LS-1]) << PRE;
        c_z_reg[0]    <= '0;
        c_neg_reg[0]  <= q_neg_reg[LS-1];
        c_zero_reg[0] <= (q_mag_reg[LS-1] == '0);
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_cordic
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic [CW-1:0]        ay;
        logic [CW-1:0]        ax;
        always_comb
        begin
            // shift toward zero
            ay = c_y_reg[k][CW-1] ? CW'(-c_y_reg[k]) : CW'(c_y_reg[k]);
            ax = c_x_reg[k][CW-1] ? CW'(-c_x_reg[k]) : CW'(c_x_reg[k]);
            dx = c_y_reg[k][CW-1] ? -$signed(ay >> k) : $signed(ay >> k);
            dy = c_x_reg[k][CW-1] ? -$signed(ax >> k) : $signed(ax >> k);
        end
        always_ff @(posedge clk)
        begin
            c_neg_reg[k+1]  <= c_neg_reg[k];
            c_zero_reg[k+1] <= c_zero_reg[k];
            if (!c_y_reg[k][CW-1])
            begin
                c_x_reg[k+1] <= c_x_reg[k] + dx;
                c_y_reg[k+1] <= c_y_reg[k] - dy;
                c_z_reg[k+1] <= c_z_reg[k] + $signed({1'b0, atan_deg(k)});
            end
            else
            begin
                c_x_reg[k+1] <= c_x_reg[k] - dx;
                c_y_reg[k+1] <= c_y_reg[k] + dy;
                c_z_reg[k+1] <= c_z_reg[k] - $signed({1'b0, atan_deg(k)});
            end
        end
    end

    // clamp, scale, sign
    logic [ZW-1:0] zpos;
    logic [AW-1:0] qv;
    logic [AW-1:0] qc;
    logic signed [AW-1:0] angle_next;
    logic signed [AW-1:0] angle_reg;
    logic                 out_v_reg;

    always_comb
    begin
        zpos = c_z_reg[NS][ZW] ? '0 : c_z_reg[NS][ZW-1:0];
        qv   = AW'(zpos >> SHV);
        qc   = (qv > LIM) ? LIM : qv;
        if (c_zero_reg[NS])
            angle_next = '0;
        else if (c_neg_reg[NS])
            angle_next = -$signed(qc);
        else
            angle_next = $signed(qc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= c_v_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign out_valid = out_v_reg;
    assign angle     = angle_reg;

endmodule
